/* rtl/lbmc_pkg.sv */
// ----------------------------------------------------------------------------
// lbmc_pkg
// Shared constants, types and lattice tables for the D3Q27 collision core.
// ----------------------------------------------------------------------------
package lbmc_pkg;

   localparam int DIST_WIDTH = 24;
   localparam int FRAC_BITS  = 18;
   localparam int NDIR       = 27;
   localparam int DIR_W      = 5;
   localparam int SUM_W      = DIST_WIDTH + 5;
   localparam int RHO_W      = 22;
   localparam int VEL_W      = FRAC_BITS + 2;
   localparam int RATE_W     = 17;
   localparam int USQ_W      = 2 * FRAC_BITS + 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = RHO_W;

   localparam logic [DIR_W-1:0]  LAST_DIR    = DIR_W'(NDIR - 1);
   localparam logic [RHO_W-1:0]  RHO_ONE     = RHO_W'(1) << FRAC_BITS;
   localparam logic [RATE_W-1:0] RATE_RESET  = 17'd109227;
   localparam logic [RHO_W-1:0]  LIMIT_RESET = 22'd2621440;
   localparam logic [31:0]       RECIP_27    = 32'd2545165808;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_GUARD,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_SQUARE,
      ST_EMIT,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic [RHO_W-1:0]        rho;
      logic signed [VEL_W-1:0] vx;
      logic signed [VEL_W-1:0] vy;
      logic signed [VEL_W-1:0] vz;
      logic [USQ_W-1:0]        usq;
      logic [RATE_W-1:0]       rate;
   } node_type;

   localparam logic signed [1:0] DIR_X [NDIR] = '{
      2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0,
      2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
      2'sd1, 2'sd0, -2'sd1, 2'sd0,
      2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
   localparam logic signed [1:0] DIR_Y [NDIR] = '{
      2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0,
      2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
      2'sd0, 2'sd1, 2'sd0, -2'sd1,
      2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
   localparam logic signed [1:0] DIR_Z [NDIR] = '{
      2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1,
      2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1,
      -2'sd1, -2'sd1, -2'sd1, -2'sd1,
      2'sd1, 2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1, -2'sd1, -2'sd1};

   function automatic logic signed [1:0] dir_comp(input logic [1:0] axis,
                                                  input logic [DIR_W-1:0] j);
      logic signed [1:0] c;
      c = 2'sd0;
      if (j <= LAST_DIR) begin
         unique case (axis)
            2'd0:    c = DIR_X[j];
            2'd1:    c = DIR_Y[j];
            default: c = DIR_Z[j];
         endcase
      end
      return c;
   endfunction

   // weight n/216 with n = 64, 16, 4, 1 as a left shift of n
   function automatic logic [2:0] weight_shift(input logic [DIR_W-1:0] j);
      logic [2:0] s;
      if (j == '0) begin
         s = 3'd6;
      end else if (j <= DIR_W'(6)) begin
         s = 3'd4;
      end else if (j <= DIR_W'(18)) begin
         s = 3'd2;
      end else begin
         s = 3'd0;
      end
      return s;
   endfunction

endpackage

/* rtl/lbmc_vel_div.sv */
// ----------------------------------------------------------------------------
// lbmc_vel_div
// Radix-2 restoring divider: momentum * 2^18 / density, rounded and clamped.
// ----------------------------------------------------------------------------
module lbmc_vel_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [lbmc_pkg::SUM_W-1:0]    mom,
   input  logic [lbmc_pkg::RHO_W-1:0]           rho,
   output logic                                 done,
   output logic signed [lbmc_pkg::VEL_W-1:0]    vel
);
   import lbmc_pkg::*;

   localparam int QB  = FRAC_BITS + 2;
   localparam int NUM_W = SUM_W + FRAC_BITS;

   logic             run_ff;
   logic [4:0]       cnt_ff;
   logic [RHO_W-1:0] rem_ff;
   logic [QB-1:0]    num_ff;
   logic [QB-1:0]    q_ff;
   logic             neg_ff;
   logic             sat_ff;
   logic             done_ff;

   logic [SUM_W-1:0] mag;
   logic [NUM_W-1:0] num_full;
   logic [RHO_W:0]   trial;
   logic             ge;
   logic [RHO_W:0]   diff;
   logic [QB-1:0]    qmag;

   assign mag      = mom[SUM_W-1] ? SUM_W'(-mom) : SUM_W'(mom);
   assign num_full = {mag, {FRAC_BITS{1'b0}}} + NUM_W'(rho >> 1);
   assign trial    = {rem_ff, num_ff[QB-1]};
   assign ge       = trial >= {1'b0, rho};
   assign diff     = trial - {1'b0, rho};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 5'(QB);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= mom[SUM_W-1];
         sat_ff <= {1'b0, mag} >= (SUM_W + 1)'({rho, 1'b0});
         rem_ff <= num_full[QB+RHO_W-1:QB];
         num_ff <= num_full[QB-1:0];
         q_ff   <= '0;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[RHO_W-1:0] : trial[RHO_W-1:0];
         num_ff <= num_ff << 1;
         q_ff   <= {q_ff[QB-2:0], ge};
      end
   end

   assign qmag = (sat_ff || q_ff > (QB'(1) << FRAC_BITS)) ? (QB'(1) << FRAC_BITS) : q_ff;
   assign vel  = neg_ff ? VEL_W'(-$signed(qmag)) : VEL_W'($signed(qmag));
   assign done = done_ff;

endmodule

/* rtl/lbmc_relax_pipe.sv */
// ----------------------------------------------------------------------------
// lbmc_relax_pipe
// Equilibrium and BGK relaxation pipeline, one direction per cycle.
// ----------------------------------------------------------------------------
module lbmc_relax_pipe (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [lbmc_pkg::DIR_W-1:0]             in_dir,
   input  logic signed [lbmc_pkg::DIST_WIDTH-1:0] in_dist,
   input  lbmc_pkg::node_type                     node,
   output logic                                   out_valid,
   output logic signed [lbmc_pkg::DIST_WIDTH-1:0] out_dist,
   output logic [lbmc_pkg::DIR_W-1:0]             out_dir,
   output logic                                   out_last,
   output logic [lbmc_pkg::RHO_W-1:0]             out_density,
   output logic signed [lbmc_pkg::VEL_W-1:0]      out_vx,
   output logic signed [lbmc_pkg::VEL_W-1:0]      out_vy,
   output logic signed [lbmc_pkg::VEL_W-1:0]      out_vz
);
   import lbmc_pkg::*;

   localparam int STAGES  = 8;
   localparam int EU_W    = VEL_W + 2;
   localparam int SQ_W    = 2 * EU_W;
   localparam int POLY_W  = 2 * FRAC_BITS + 9;
   localparam int POLYF_W = 26;
   localparam int PROD_W  = RHO_W + 1 + POLYF_W;
   localparam int SH_W    = PROD_W + 6;
   localparam int M_W     = 31;
   localparam int Q_W     = 27;
   localparam int FEQ_W   = 28;
   localparam int DIFF_W  = FEQ_W + 1;
   localparam int MUL_W   = DIFF_W + RATE_W + 1;
   localparam int RD_W    = MUL_W - 16;
   localparam int R_W     = RD_W + 2;

   localparam logic signed [POLY_W-1:0] POLY_ONE = POLY_W'(1) <<< (2 * FRAC_BITS + 1);
   localparam logic [POLY_W-1:0]        POLY_HALF = POLY_W'(1) << FRAC_BITS;
   localparam logic [SH_W-1:0]          FEQ_HALF = SH_W'(27) << (FRAC_BITS + 2);
   localparam logic signed [R_W-1:0]    DMAX = R_W'((64'sd1 <<< (DIST_WIDTH - 1)) - 1);
   localparam logic signed [R_W-1:0]    DMIN = -(R_W'(64'sd1 <<< (DIST_WIDTH - 1)));

   logic [STAGES-1:0]               valid_ff;
   logic signed [DIST_WIDTH-1:0]    dist_ff [STAGES];
   logic [DIR_W-1:0]                dir_ff  [STAGES];

   logic signed [EU_W-1:0]    eu_a_ff, eu_b_ff;
   logic signed [SQ_W-1:0]    sq_b_ff;
   logic signed [POLYF_W-1:0] polyf_c_ff;
   logic signed [PROD_W-1:0]  prod_d_ff;
   logic [M_W-1:0]            m_e_ff, m_f_ff;
   logic                      neg_e_ff, neg_f_ff;
   logic [Q_W-1:0]            q_f_ff;
   logic signed [FEQ_W-1:0]   feq_g_ff;
   logic signed [MUL_W-1:0]   mul_h_ff;

   logic signed [EU_W-1:0]    eu;
   logic signed [POLY_W-1:0]  eu_ext, usq_ext, poly;
   logic [POLY_W-1:0]         pmag, pround;
   logic [PROD_W-1:0]         prmag;
   logic [SH_W-1:0]           shifted;
   logic [63:0]               qprod;
   logic [31:0]               q27;
   logic [Q_W-1:0]            qcor;
   logic signed [DIFF_W-1:0]  diff;
   logic [MUL_W-1:0]          mmag, mround;
   logic signed [R_W-1:0]     rd, r;

   function automatic logic signed [EU_W-1:0] term(input logic signed [1:0] c,
                                                   input logic signed [VEL_W-1:0] v);
      logic signed [EU_W-1:0] t;
      t = '0;
      if (c == 2'sd1) begin
         t = EU_W'(v);
      end else if (c == -2'sd1) begin
         t = -EU_W'(v);
      end
      return t;
   endfunction

   assign eu = term(dir_comp(2'd0, in_dir), node.vx) + term(dir_comp(2'd1, in_dir), node.vy)
             + term(dir_comp(2'd2, in_dir), node.vz);

   assign eu_ext  = POLY_W'(eu_b_ff);
   assign usq_ext = $signed({{(POLY_W-USQ_W){1'b0}}, node.usq});
   assign poly    = POLY_ONE + (((eu_ext <<< 2) + (eu_ext <<< 1)) <<< FRAC_BITS)
                  + (POLY_W'(sq_b_ff) <<< 3) + POLY_W'(sq_b_ff)
                  - ((usq_ext <<< 1) + usq_ext);
   assign pmag    = poly[POLY_W-1] ? POLY_W'(-poly) : POLY_W'(poly);
   assign pround  = pmag + POLY_HALF;

   assign prmag   = prod_d_ff[PROD_W-1] ? PROD_W'(-prod_d_ff) : PROD_W'(prod_d_ff);
   assign shifted = (SH_W'(prmag) << weight_shift(dir_ff[3])) + FEQ_HALF;

   assign qprod = 64'(m_e_ff) * 64'(RECIP_27);
   assign q27   = (32'(q_f_ff) << 4) + (32'(q_f_ff) << 3) + (32'(q_f_ff) << 1) + 32'(q_f_ff);
   assign qcor  = (q27 > 32'(m_f_ff)) ? q_f_ff - Q_W'(1) : q_f_ff;

   assign diff   = DIFF_W'(dist_ff[6]) - DIFF_W'(feq_g_ff);
   assign mmag   = mul_h_ff[MUL_W-1] ? MUL_W'(-mul_h_ff) : MUL_W'(mul_h_ff);
   assign mround = mmag + MUL_W'(32768);
   assign rd     = mul_h_ff[MUL_W-1] ? -$signed(R_W'(mround[MUL_W-1:16]))
                                     : $signed(R_W'(mround[MUL_W-1:16]));
   assign r      = R_W'(dist_ff[7]) - rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         out_valid <= 1'b0;
      end else begin
         valid_ff  <= {valid_ff[STAGES-2:0], in_valid};
         out_valid <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      dist_ff[0] <= in_dist;
      dir_ff[0]  <= in_dir;
      for (int s = 1; s < STAGES; s++) begin
         dist_ff[s] <= dist_ff[s-1];
         dir_ff[s]  <= dir_ff[s-1];
      end
      eu_a_ff    <= eu;
      eu_b_ff    <= eu_a_ff;
      sq_b_ff    <= eu_a_ff * eu_a_ff;
      polyf_c_ff <= poly[POLY_W-1] ? -$signed(pround[POLYF_W+FRAC_BITS:FRAC_BITS+1])
                                   : $signed(pround[POLYF_W+FRAC_BITS:FRAC_BITS+1]);
      prod_d_ff  <= $signed({1'b0, node.rho}) * polyf_c_ff;
      m_e_ff     <= shifted[M_W+FRAC_BITS+2:FRAC_BITS+3];
      neg_e_ff   <= prod_d_ff[PROD_W-1];
      q_f_ff     <= qprod[Q_W+35:36];
      m_f_ff     <= m_e_ff;
      neg_f_ff   <= neg_e_ff;
      feq_g_ff   <= neg_f_ff ? -$signed(FEQ_W'(qcor)) : $signed(FEQ_W'(qcor));
      mul_h_ff   <= diff * $signed({1'b0, node.rate});
      if (r > DMAX) begin
         out_dist <= DMAX[DIST_WIDTH-1:0];
      end else if (r < DMIN) begin
         out_dist <= DMIN[DIST_WIDTH-1:0];
      end else begin
         out_dist <= r[DIST_WIDTH-1:0];
      end
      out_dir     <= dir_ff[7];
      out_last    <= dir_ff[7] == LAST_DIR;
      out_density <= (dir_ff[7] == LAST_DIR) ? node.rho : '0;
      out_vx      <= (dir_ff[7] == LAST_DIR) ? node.vx : '0;
      out_vy      <= (dir_ff[7] == LAST_DIR) ? node.vy : '0;
      out_vz      <= (dir_ff[7] == LAST_DIR) ? node.vz : '0;
   end

endmodule

/* rtl/lbm_d3q27_node_collision_core.sv */
// ----------------------------------------------------------------------------
// lbm_d3q27_node_collision_core
// D3Q27 BGK collision for one fluid node in Q5.18 fixed point.
//
// Input: pulse start with req_dist_in while busy is low; one transaction per
// direction, 0 to 26 in order. Directions 0..25 are accepted and busy
// stays low. The 27th value starts the node: busy rises, density and velocity
// are formed (three divisions of 20 quotient steps each on one shared
// divider, each followed by a squaring step), then the stored values are read
// back from the node memory one per cycle into a 9-stage relaxation pipeline.
// Output: rsp_valid marks directions 0..26 on consecutive cycles; the last
// one carries rsp_last_out, the guarded density and the clamped velocity.
// Busy stays high up to the last result, so no new node is taken before it.
// The receiver cannot stall; results are shown for one cycle each.
// Registers are to be written via csr_write/csr_index/csr_data while idle;
// the core itself does not enforce this.
// Reset clears the control state and loads the register defaults.
// ----------------------------------------------------------------------------
module lbm_d3q27_node_collision_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [lbmc_pkg::DIST_WIDTH-1:0]    req_dist_in,
   output logic                                      rsp_valid,
   output logic signed [lbmc_pkg::DIST_WIDTH-1:0]    rsp_dist_out,
   output logic [lbmc_pkg::DIR_W-1:0]                rsp_direction_out,
   output logic                                      rsp_last_out,
   output logic [lbmc_pkg::RHO_W-1:0]                rsp_density_out,
   output logic signed [lbmc_pkg::VEL_W-1:0]         rsp_vel_x_out,
   output logic signed [lbmc_pkg::VEL_W-1:0]         rsp_vel_y_out,
   output logic signed [lbmc_pkg::VEL_W-1:0]         rsp_vel_z_out,
   input  logic                                      csr_write,
   input  logic [lbmc_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [lbmc_pkg::CSR_DATA_W-1:0]           csr_data
);
   import lbmc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [DIR_W-1:0]  cnt_ff;
   logic [1:0]        k_ff, k_in;
   logic [DIR_W-1:0]  j_ff, j_in;
   logic [RATE_W-1:0] rate_ff;
   logic [RHO_W-1:0]  limit_ff;

   logic signed [SUM_W-1:0] rho_sum_ff, mx_ff, my_ff, mz_ff;
   logic [RHO_W-1:0]        rho_ff;
   logic signed [VEL_W-1:0] vx_ff, vy_ff, vz_ff;
   logic [USQ_W-1:0]        usq_ff;

   logic signed [DIST_WIDTH-1:0] dist_store [NDIR];
   logic signed [DIST_WIDTH-1:0] rd_ff;
   logic                         iss_valid_ff;
   logic [DIR_W-1:0]             iss_dir_ff;

   logic                    accept;
   logic                    first;
   logic                    div_start;
   logic                    div_done;
   logic signed [VEL_W-1:0] div_vel;
   logic signed [SUM_W-1:0] div_mom;
   logic signed [VEL_W-1:0] sq_vel;
   logic signed [SUM_W-1:0] f_ext;
   node_type                node;

   function automatic logic signed [SUM_W-1:0] dterm(input logic signed [1:0] c,
                                                     input logic signed [SUM_W-1:0] f);
      logic signed [SUM_W-1:0] t;
      t = '0;
      if (c == 2'sd1) begin
         t = f;
      end else if (c == -2'sd1) begin
         t = -f;
      end
      return t;
   endfunction

   assign accept = start && !busy;
   assign busy   = state_ff != ST_COLLECT;
   assign first  = cnt_ff == '0;
   assign f_ext  = SUM_W'(req_dist_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RATE:  rate_ff  <= csr_data[RATE_W-1:0];
            CSR_LIMIT: limit_ff <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         cnt_ff       <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         iss_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         iss_valid_ff <= state_ff == ST_EMIT;
         if (accept) begin
            cnt_ff <= (cnt_ff == LAST_DIR) ? '0 : cnt_ff + DIR_W'(1);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept && cnt_ff == LAST_DIR) begin
               state_in = ST_GUARD;
            end
         end
         ST_GUARD: begin
            k_in     = '0;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (k_ff == 2'd2) begin
               j_in     = '0;
               state_in = ST_EMIT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_EMIT: begin
            if (j_ff == LAST_DIR) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + DIR_W'(1);
            end
         end
         ST_DRAIN: begin
            if (rsp_valid && rsp_last_out) begin
               state_in = ST_COLLECT;
            end
         end
      endcase
   end

   // node memory
   always_ff @(posedge clock) begin
      if (accept) begin
         dist_store[cnt_ff] <= req_dist_in;
      end
      rd_ff      <= dist_store[j_ff];
      iss_dir_ff <= j_ff;
   end

   // running moments
   always_ff @(posedge clock) begin
      if (accept) begin
         rho_sum_ff <= (first ? '0 : rho_sum_ff) + f_ext;
         mx_ff      <= (first ? '0 : mx_ff) + dterm(dir_comp(2'd0, cnt_ff), f_ext);
         my_ff      <= (first ? '0 : my_ff) + dterm(dir_comp(2'd1, cnt_ff), f_ext);
         mz_ff      <= (first ? '0 : mz_ff) + dterm(dir_comp(2'd2, cnt_ff), f_ext);
      end
      if (state_ff == ST_GUARD) begin
         if (rho_sum_ff <= 0 || rho_sum_ff > $signed(SUM_W'(limit_ff))) begin
            rho_ff <= RHO_ONE;
         end else begin
            rho_ff <= rho_sum_ff[RHO_W-1:0];
         end
         usq_ff <= '0;
      end
      if (state_ff == ST_DIV_RUN && div_done) begin
         unique case (k_ff)
            2'd0:    vx_ff <= div_vel;
            2'd1:    vy_ff <= div_vel;
            default: vz_ff <= div_vel;
         endcase
      end
      if (state_ff == ST_SQUARE) begin
         usq_ff <= usq_ff + USQ_W'(sq_vel * sq_vel);
      end
   end

   always_comb begin
      unique case (k_ff)
         2'd0: begin
            div_mom = mx_ff;
            sq_vel  = vx_ff;
         end
         2'd1: begin
            div_mom = my_ff;
            sq_vel  = vy_ff;
         end
         default: begin
            div_mom = mz_ff;
            sq_vel  = vz_ff;
         end
      endcase
   end

   assign node = '{rho: rho_ff, vx: vx_ff, vy: vy_ff, vz: vz_ff, usq: usq_ff, rate: rate_ff};

   lbmc_vel_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mom   (div_mom),
      .rho   (rho_ff),
      .done  (div_done),
      .vel   (div_vel)
   );

   lbmc_relax_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (iss_valid_ff),
      .in_dir      (iss_dir_ff),
      .in_dist     (rd_ff),
      .node        (node),
      .out_valid   (rsp_valid),
      .out_dist    (rsp_dist_out),
      .out_dir     (rsp_direction_out),
      .out_last    (rsp_last_out),
      .out_density (rsp_density_out),
      .out_vx      (rsp_vel_x_out),
      .out_vy      (rsp_vel_y_out),
      .out_vz      (rsp_vel_z_out)
   );

endmodule

/* rtl/lbmc_checker.sv */
// ----------------------------------------------------------------------------
// lbmc_checker
// Port-level checks on the result stream of the collision core.
// ----------------------------------------------------------------------------
module lbmc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [lbmc_pkg::DIR_W-1:0]         rsp_direction_out,
   input logic                               rsp_last_out,
   input logic [lbmc_pkg::RHO_W-1:0]         rsp_density_out
);
   import lbmc_pkg::*;

   // results only stream while the node is being processed
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside busy window");

   // directions come out consecutively within a node
   a_dir_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction_out != '0 |->
         $past(rsp_valid) && $past(rsp_direction_out) == rsp_direction_out - DIR_W'(1))
      else $error("direction sequence broken");

   // last flag only on the final direction
   a_last_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out |-> rsp_direction_out == LAST_DIR)
      else $error("last flag on wrong direction");

   // guarded density is never zero
   a_density: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out |-> rsp_density_out != '0)
      else $error("zero density reported");

   // busy drops right after the final result
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out |=> !busy)
      else $error("busy held after node");

endmodule

bind lbm_d3q27_node_collision_core lbmc_checker u_lbmc_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the D3Q27 node collision core. Nodes of 27 values
// are driven with random gaps; a built-in predictor sums density and momentum,
// guards the density, divides and clamps velocity, forms the equilibrium and
// relaxes each value. Every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import lbmc_pkg::*;

   typedef struct {
      logic signed [23:0] dist_val;
      logic [4:0]         dir;
      logic               last;
      logic [21:0]        rho;
      logic signed [19:0] vx;
      logic signed [19:0] vy;
      logic signed [19:0] vz;
   } collision_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [23:0] req_dist_in = '0;
   logic rsp_valid;
   logic signed [23:0] rsp_dist_out;
   logic [4:0] rsp_direction_out;
   logic rsp_last_out;
   logic [21:0] rsp_density_out;
   logic signed [19:0] rsp_vel_x_out, rsp_vel_y_out, rsp_vel_z_out;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RATE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   lbm_d3q27_node_collision_core dut (.*);

   logic signed [23:0]   pending_dists [$];
   collision_result_type expected_results [$];
   longint node_vals [NDIR];
   int     node_fill = 0;
   longint omega = 109227;
   longint rho_limit = 2621440;
   int     error_count = 0;
   int     result_count = 0;
   int     node_count = 0;
   int     gap = 0;
   longint cycle_count = 0;

   initial forever #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic longint div_round(input longint num, input longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clamp_one(input longint v);
      if (v > 262144) return 262144;
      if (v < -262144) return -262144;
      return v;
   endfunction

   function automatic longint weight_of(input int j);
      if (j == 0) return 64;
      if (j <= 6) return 16;
      if (j <= 18) return 4;
      return 1;
   endfunction

   // predict the 27 post-collision values of a full node
   task automatic predict_collision();
      longint rho, mx, my, mz, ux, uy, uz, usq, eu, poly, feq, f, r;
      collision_result_type res;
      rho = 0; mx = 0; my = 0; mz = 0;
      for (int j = 0; j < NDIR; j++) begin
         rho += node_vals[j];
         mx += DIR_X[j] * node_vals[j];
         my += DIR_Y[j] * node_vals[j];
         mz += DIR_Z[j] * node_vals[j];
      end
      if (rho <= 0 || rho > rho_limit) rho = 262144;
      ux = clamp_one(div_round(mx * 262144, rho));
      uy = clamp_one(div_round(my * 262144, rho));
      uz = clamp_one(div_round(mz * 262144, rho));
      usq = ux * ux + uy * uy + uz * uz;
      for (int j = 0; j < NDIR; j++) begin
         eu = DIR_X[j] * ux + DIR_Y[j] * uy + DIR_Z[j] * uz;
         poly = (64'sd1 <<< 37) + 6 * eu * 262144 + 9 * eu * eu - 3 * usq;
         poly = div_round(poly, 64'sd1 <<< 19);
         feq = div_round(rho * weight_of(j) * poly, 216 * 262144);
         f = node_vals[j];
         r = f - div_round((f - feq) * omega, 65536);
         if (r > 8388607) r = 8388607;
         if (r < -8388608) r = -8388608;
         res.dist_val = r[23:0];
         res.dir = j[4:0];
         res.last = (j == NDIR - 1);
         res.rho = res.last ? rho[21:0] : '0;
         res.vx = res.last ? ux[19:0] : '0;
         res.vy = res.last ? uy[19:0] : '0;
         res.vz = res.last ? uz[19:0] : '0;
         expected_results.push_back(res);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (start && !busy) begin
         node_vals[node_fill] = req_dist_in;
         node_fill++;
         if (node_fill == NDIR) begin
            predict_collision();
            node_fill = 0;
            node_count++;
         end
      end
      if (!reset && (!start || !busy)) begin
         if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
         end else if (pending_dists.size() > 0) begin
            start <= 1'b1;
            req_dist_in <= pending_dists.pop_front();
            gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      collision_result_type want;
      cycle_count++;
      if (!reset && rsp_valid) begin
         result_count++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result dir", rsp_direction_out, -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_dist_out !== want.dist_val)
               report_mismatch("dist", rsp_dist_out, want.dist_val);
            if (rsp_direction_out !== want.dir)
               report_mismatch("direction", rsp_direction_out, want.dir);
            if (rsp_last_out !== want.last) report_mismatch("last", rsp_last_out, want.last);
            if (rsp_density_out !== want.rho)
               report_mismatch("density", rsp_density_out, want.rho);
            if (rsp_vel_x_out !== want.vx) report_mismatch("vel_x", rsp_vel_x_out, want.vx);
            if (rsp_vel_y_out !== want.vy) report_mismatch("vel_y", rsp_vel_y_out, want.vy);
            if (rsp_vel_z_out !== want.vz) report_mismatch("vel_z", rsp_vel_z_out, want.vz);
         end
      end
      if (cycle_count > 400000) begin
         $display("timeout waiting for results");
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input longint value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_RATE) omega = value & 64'h1FFFF;
      else rho_limit = value & 64'h3FFFFF;
   endtask

   task automatic wait_idle();
      while (pending_dists.size() > 0 || expected_results.size() > 0 || start || busy)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // kind: 0 typical, 1 random full range, 2 moving flow, 3 nonpositive density
   task automatic queue_node(input int kind);
      longint v;
      int sx;
      sx = $urandom_range(0, 26);
      for (int j = 0; j < NDIR; j++) begin
         case (kind)
            0: v = (weight_of(j) * 262144) / 216 + $signed($urandom_range(0, 4000)) - 2000;
            1: v = $signed($urandom_range(0, 16777215)) - 8388608;
            2: v = (j == sx) ? $urandom_range(0, 2000000) : $urandom_range(0, 30000);
            default: v = -$signed($urandom_range(0, 100000));
         endcase
         pending_dists.push_back(v[23:0]);
      end
   endtask

   task automatic queue_fixed_node(input longint v);
      for (int j = 0; j < NDIR; j++) pending_dists.push_back(v[23:0]);
   endtask

   task automatic run_random(input int nodes);
      for (int n = 0; n < nodes; n++) begin
         case ($urandom_range(0, 9))
            0, 1:    queue_node(1);
            2, 3, 4: queue_node(2);
            9:       queue_node(3);
            default: queue_node(0);
         endcase
      end
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, zero density, over-limit density, typical rest state
      queue_fixed_node(8388607);
      queue_fixed_node(-8388608);
      queue_fixed_node(0);
      queue_node(0);
      wait_idle();
      write_reg(CSR_RATE, 65536);
      write_reg(CSR_LIMIT, 262144);
      run_random(2);
      write_reg(CSR_RATE, 131071);
      write_reg(CSR_LIMIT, 2621440);
      run_random(3);
      write_reg(CSR_RATE, 0);
      write_reg(CSR_LIMIT, 4194303);
      run_random(2);
      write_reg(CSR_RATE, $urandom_range(65536, 131071));
      write_reg(CSR_LIMIT, $urandom_range(262144, 2621440));
      run_random(3);
      $display("covered %0d nodes, %0d results checked, rate and limit at extremes",
               node_count, result_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lbmc_pkg.sv
rtl/lbmc_vel_div.sv
rtl/lbmc_relax_pipe.sv
rtl/lbm_d3q27_node_collision_core.sv
rtl/lbmc_checker.sv
dv/tb.sv
